// File: rtl/core/datagram_header_parser_defines.svh
// Assertion macros for the datagram header parser checker.
// Used by dhp_checker.sv; needs nothing else.
`ifndef DATAGRAM_HEADER_PARSER_DEFINES_SVH
`define DATAGRAM_HEADER_PARSER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define DHP_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define DHP_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/dhp_pkg.sv
// Types, constants and name lookup for the datagram header parser.
// No dependencies; imported by every module of the block.
package dhp_pkg;

	localparam int NAME_LEN = 10;
	localparam int NUM_NAMES = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] NAME_END = 16'd10;
	localparam logic [15:0] SEQ_END = 16'd18;
	localparam logic [15:0] PARAM_END = 16'd26;

	localparam logic [2:0] ST_SIMPLE_OK = 3'd0;
	localparam logic [2:0] ST_COMPLEX_OK = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_COMPLEX_SHORT = 3'd4;

	localparam logic [3:0] CMD_FIRST_COMPLEX = 4'd6;
	localparam logic [3:0] CMD_UNKNOWN = 4'd10;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef logic [0:NAME_LEN-1][7:0] name_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [3:0]  command_code;
		logic [63:0] sequence_number;
		logic [63:0] parameter_value;
		logic [15:0] message_size;
		logic [15:0] payload_length;
		logic        end_of_run;
	} out_item_t;

	typedef struct packed {
		logic        pay_valid;
		logic [7:0]  pay_byte;
		logic        sum_valid;
		logic [2:0]  status;
		logic [3:0]  code;
		logic [63:0] seq;
		logic [63:0] par;
		logic [15:0] size;
		logic [15:0] plen;
	} entry_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} q_status_t;

	function automatic name_t known_name(input logic [3:0] idx);
		name_t r;
		unique case (idx)
			4'd0: r = {"HELLO", 40'd0};
			4'd1: r = {"LIST", 48'd0};
			4'd2: r = {"DEL", 56'd0};
			4'd3: r = {"NO_WAY", 32'd0};
			4'd4: r = {"MY_LIST", 24'd0};
			4'd5: r = {"GET", 56'd0};
			4'd6: r = {"GOOD", "_DAY", 16'd0};
			4'd7: r = {"CONNECT", "_ME"};
			4'd8: r = {"ADD", 56'd0};
			4'd9: r = {"CAN_ADD", 24'd0};
			default: r = '1;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] lookup_code(input name_t name);
		name_t cut;
		logic seen;
		logic [3:0] code;
		seen = 1'b0;
		code = CMD_UNKNOWN;
		for (int i = 0; i < NAME_LEN; i++) begin
			if (name[i] == 8'd0) begin
				seen = 1'b1;
			end
			cut[i] = seen ? 8'd0 : name[i];
		end
		for (int i = NUM_NAMES - 1; i >= 0; i--) begin
			if (cut == known_name(4'(i))) begin
				code = 4'(i);
			end
		end
		return code;
	endfunction

endpackage

// File: rtl/core/dhp_front.sv
// Front end: accepts datagram bytes, tracks header position and decodes fields.
// Pushes one queue entry per byte that yields a result. Depends on dhp_pkg.
module dhp_front import dhp_pkg::*; #(
	parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	input  q_status_t q_status,
	output logic      push,
	output entry_t    push_entry
);

	localparam logic [15:0] MAX_BYTES = 16'(MAX_MESSAGE_BYTES);

	logic [15:0] pos_q;
	name_t       name_q;
	logic [63:0] seq_q;
	logic [63:0] par_q;
	logic        stopped_q;
	logic [15:0] count_q;

	logic        accept;
	logic [7:0]  b;
	logic [15:0] size;
	logic [3:0]  code;
	logic        known, complex_cmd;
	logic        in_name, in_seq, in_tail;
	logic        par_take, is_pay, emit, stop_set;
	logic [15:0] count_n;
	logic [63:0] seq_n, par_n;
	logic [2:0]  status;
	logic [3:0]  sum_code;
	logic [63:0] sum_seq, sum_par;
	logic [15:0] sum_plen;

	assign byte_stall = q_status.full;
	assign accept = byte_valid && !byte_stall;
	assign b = byte_item.data_byte;

	always_comb begin
		size = (pos_q < MAX_BYTES) ? pos_q + 16'd1 : MAX_BYTES;
		code = lookup_code(name_q);
		known = code != CMD_UNKNOWN;
		complex_cmd = code >= CMD_FIRST_COMPLEX;
		in_name = pos_q < NAME_END;
		in_seq = !in_name && pos_q < SEQ_END;
		in_tail = !in_name && !in_seq;
		par_take = in_tail && known && complex_cmd && pos_q < PARAM_END;
		is_pay = in_tail && known && !par_take;
		emit = is_pay && !stopped_q && b != 8'd0;
		stop_set = is_pay && !stopped_q && b == 8'd0;
		count_n = (emit && count_q < MAX_BYTES) ? count_q + 16'd1 : count_q;
		seq_n = in_seq ? {seq_q[55:0], b} : seq_q;
		par_n = par_take ? {par_q[55:0], b} : par_q;

		sum_code = CMD_UNKNOWN;
		sum_seq = '0;
		sum_par = '0;
		sum_plen = '0;
		if (size < SEQ_END) begin
			status = ST_TOO_SHORT;
		end else if (!known) begin
			status = ST_UNKNOWN;
		end else if (complex_cmd) begin
			sum_code = code;
			if (size < PARAM_END) begin
				status = ST_COMPLEX_SHORT;
			end else begin
				status = ST_COMPLEX_OK;
				sum_seq = seq_n;
				sum_par = par_n;
				sum_plen = count_n;
			end
		end else begin
			status = ST_SIMPLE_OK;
			sum_code = code;
			sum_seq = seq_n;
			sum_plen = count_n;
		end
	end

	assign push = accept && (emit || byte_item.last_byte);

	always_comb begin
		push_entry.pay_valid = emit;
		push_entry.pay_byte = b;
		push_entry.sum_valid = byte_item.last_byte;
		push_entry.status = status;
		push_entry.code = sum_code;
		push_entry.seq = sum_seq;
		push_entry.par = sum_par;
		push_entry.size = size;
		push_entry.plen = sum_plen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			name_q <= '0;
			seq_q <= '0;
			par_q <= '0;
			stopped_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (byte_item.last_byte) begin
				pos_q <= '0;
				name_q <= '0;
				seq_q <= '0;
				par_q <= '0;
				stopped_q <= 1'b0;
				count_q <= '0;
			end else begin
				pos_q <= size;
				if (in_name) begin
					name_q[pos_q[3:0]] <= b;
				end
				seq_q <= seq_n;
				par_q <= par_n;
				if (stop_set) begin
					stopped_q <= 1'b1;
				end
				count_q <= count_n;
			end
		end
	end

endmodule

// File: rtl/core/dhp_queue.sv
// Short FIFO of decoded entries between front and back ends.
// Flip-flop storage, one push and one pop per cycle. Depends on dhp_pkg.
module dhp_queue import dhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t q_status
);

	entry_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_q, rd_q;
	logic [QUEUE_AW:0]    count_q;

	assign head = mem_q[rd_q];
	assign q_status.nonempty = count_q != '0;
	assign q_status.full = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/dhp_back.sv
// Back end: expands queue entries into payload and summary results.
// Drives the registered result channel. Depends on dhp_pkg.
module dhp_back import dhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	logic      valid_q;
	out_item_t item_q;
	logic      phase_q;

	logic      load, take, pay_now;
	out_item_t res;

	assign load = !valid_q || !result_stall;
	assign take = q_status.nonempty && load;
	assign pay_now = head.pay_valid && !phase_q;
	assign pop = take && (!pay_now || !head.sum_valid);

	always_comb begin
		if (pay_now) begin
			res = '0;
			res.result_kind = KIND_PAYLOAD;
			res.payload_byte = head.pay_byte;
			res.end_of_run = !head.sum_valid;
		end else begin
			res.result_kind = KIND_SUMMARY;
			res.payload_byte = 8'd0;
			res.status = head.status;
			res.command_code = head.code;
			res.sequence_number = head.seq;
			res.parameter_value = head.par;
			res.message_size = head.size;
			res.payload_length = head.plen;
			res.end_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= q_status.nonempty;
			end
			if (take) begin
				phase_q <= pay_now && head.sum_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign result_item = item_q;

endmodule

// File: rtl/core/datagram_header_parser.sv
// Datagram header parser, top level.
// Byte channel in (byte_valid, byte_stall, byte_item: data_byte, last_byte),
// result channel out (result_valid, result_stall, result_item).
// A datagram arrives one byte per beat; last_byte marks its final byte.
// Bytes 0-9 carry a NUL-padded command name, 10-17 a big-endian sequence,
// 18-25 a big-endian parameter for complex commands; payload bytes follow
// and, for a known command, each one before the first zero byte becomes a payload result.
// The final byte also yields a summary result after any payload result.
// Throughput: one byte per cycle while byte_stall is low. A byte that
// yields two results sends them one after the other; a four-entry queue
// between the decode front end and the result back end absorbs this,
// and byte_stall rises when it fills. result_valid rises once a byte's
// entry has passed the queue and the output register. Bytes that yield
// no result leave the queue untouched. When result_stall is high the
// output register holds its beat and the queue keeps filling. Reset
// clears the parse state, the queue and the output valid; the next byte after reset starts a new datagram.
// Depends on dhp_pkg, dhp_front, dhp_queue, dhp_back.
module datagram_header_parser import dhp_pkg::*; #(
	parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	q_status_t q_status;
	logic      push, pop;
	entry_t    push_entry, head;

	dhp_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	dhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	dhp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

// File: rtl/core/dhp_checker.sv
// Port-level checks on the datagram header parser result channel.
// Depends on dhp_pkg and datagram_header_parser_defines.svh; bound to the top level.
`include "datagram_header_parser_defines.svh"

module dhp_checker import dhp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result_item
);

	`DHP_ASSERT_NEXT(a_hold_stalled, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result_item), "stalled result beat changed")

	`DHP_ASSERT_NOW(a_payload_clean, clk, arst_n,
		result_valid && result_item.result_kind == KIND_PAYLOAD,
		result_item.status == ST_SIMPLE_OK && result_item.command_code == 4'd0 &&
		result_item.sequence_number == 64'd0 && result_item.message_size == 16'd0 &&
		result_item.payload_byte != 8'd0, "malformed payload result")

	`DHP_ASSERT_NOW(a_summary_ends, clk, arst_n,
		result_valid && result_item.result_kind == KIND_SUMMARY,
		result_item.end_of_run && result_item.payload_byte == 8'd0 &&
		result_item.message_size != 16'd0, "malformed summary result")

	`DHP_ASSERT_NOW(a_failed_fields, clk, arst_n,
		result_valid && (result_item.status == ST_TOO_SHORT ||
		result_item.status == ST_UNKNOWN),
		result_item.command_code == CMD_UNKNOWN &&
		result_item.sequence_number == 64'd0 &&
		result_item.payload_length == 16'd0, "failed summary carries fields")

endmodule

bind datagram_header_parser dhp_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);
